// ===== rtl/irhc_pkg.sv =====
package irhc_pkg;

  typedef enum logic [3:0] {
    VERDICT_ACCEPT   = 4'd0,
    VERDICT_SHORT    = 4'd1,
    VERDICT_VERSION  = 4'd2,
    VERDICT_HDR_LEN  = 4'd3,
    VERDICT_CHECKSUM = 4'd4,
    VERDICT_TOT_LEN  = 4'd5,
    VERDICT_NOT_OURS = 4'd6,
    VERDICT_FRAGMENT = 4'd7,
    VERDICT_PROTOCOL = 4'd8
  } verdict_t;

  localparam logic       REG_LOCAL_ADDR  = 1'b0;
  localparam logic       REG_SUBNET_MASK = 1'b1;

  localparam logic [15:0] MIN_HEADER     = 16'd20;
  localparam logic [3:0]  IP_VERSION4    = 4'd4;
  localparam logic [7:0]  PROTO_ICMP     = 8'd1;
  localparam logic [7:0]  LOOPBACK_NET   = 8'd127;
  localparam logic [31:0] ALL_ONES_ADDR  = 32'hFFFF_FFFF;
  localparam logic [15:0] COUNT_MAX      = 16'hFFFF;
  localparam logic [15:0] CSUM_GOOD      = 16'hFFFF;

  localparam logic [15:0] POS_VIHL       = 16'd0;
  localparam logic [15:0] POS_TLEN_HI    = 16'd2;
  localparam logic [15:0] POS_TLEN_LO    = 16'd3;
  localparam logic [15:0] POS_FRAG_HI    = 16'd6;
  localparam logic [15:0] POS_FRAG_LO    = 16'd7;
  localparam logic [15:0] POS_PROTO      = 16'd9;
  localparam logic [15:0] POS_SRC_FIRST  = 16'd12;
  localparam logic [15:0] POS_SRC_LAST   = 16'd15;
  localparam logic [15:0] POS_DST_FIRST  = 16'd16;
  localparam logic [15:0] POS_DST_LAST   = 16'd19;

endpackage

// ===== rtl/ipv4_receive_header_check_core.sv =====
// a finished packet is held in the snapshot registers, then moved to the result word
// throughput: one packet byte per cycle; stall on the input only while a finished
//   verdict waits behind a stalled output
// per-byte work is a count, a field capture and a 16-bit end-around-carry add
// reset (rst_n low, synchronous) clears the byte count, header capture, both
//   configuration registers and all valid flags
module ipv4_receive_header_check_core
  import irhc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_packet_byte,
  input  logic        in_last_byte,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_verdict,
  output logic [7:0]  out_protocol_number,
  output logic [31:0] out_source_address,
  output logic [31:0] out_destination_address,
  output logic [5:0]  out_header_bytes,
  output logic [15:0] out_payload_bytes,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration
  logic [31:0] local_addr_r;
  logic [31:0] subnet_mask_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_addr_r  <= '0;
      subnet_mask_r <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_LOCAL_ADDR:  local_addr_r  <= pwdata;
        REG_SUBNET_MASK: subnet_mask_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_LOCAL_ADDR:  prdata = local_addr_r;
      REG_SUBNET_MASK: prdata = subnet_mask_r;
      default:         prdata = '0;
    endcase
  end

  // handshake
  logic snap_valid_r;
  logic out_valid_r;
  logic out_free;
  logic snap_move;
  logic in_acc;

  assign out_free  = !out_valid_r || !out_stall;
  assign snap_move = snap_valid_r && out_free;
  assign in_stall  = snap_valid_r && !out_free;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  // per-packet accumulation
  logic [15:0] byte_count_r, byte_count_nxt;
  logic [7:0]  vihl_r, vihl_nxt;
  logic [15:0] tlen_r, tlen_nxt;
  logic [15:0] frag_r, frag_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [31:0] src_r, src_nxt;
  logic [31:0] dst_r, dst_nxt;
  logic [15:0] csum_r, csum_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic [5:0]  hlen_cur;
  logic        in_hdr;
  logic [16:0] csum_add;
  logic [15:0] pos;

  assign pos = byte_count_r;

  always_comb begin
    vihl_nxt  = vihl_r;
    tlen_nxt  = tlen_r;
    frag_nxt  = frag_r;
    proto_nxt = proto_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    csum_nxt  = csum_r;
    hold_nxt  = hold_r;

    if (pos == POS_VIHL)         vihl_nxt = in_packet_byte;
    else if (pos == POS_TLEN_HI) tlen_nxt = {in_packet_byte, tlen_r[7:0]};
    else if (pos == POS_TLEN_LO) tlen_nxt = {tlen_r[15:8], in_packet_byte};
    else if (pos == POS_FRAG_HI) frag_nxt = {in_packet_byte, frag_r[7:0]};
    else if (pos == POS_FRAG_LO) frag_nxt = {frag_r[15:8], in_packet_byte};
    else if (pos == POS_PROTO)   proto_nxt = in_packet_byte;
    else if (pos >= POS_SRC_FIRST && pos <= POS_SRC_LAST)
      src_nxt = {src_r[23:0], in_packet_byte};
    else if (pos >= POS_DST_FIRST && pos <= POS_DST_LAST)
      dst_nxt = {dst_r[23:0], in_packet_byte};

    hlen_cur = {vihl_nxt[3:0], 2'b00};
    in_hdr   = pos < {10'd0, hlen_cur};
    csum_add = {1'b0, csum_r} + {1'b0, hold_r, in_packet_byte};

    if (in_hdr) begin
      if (!pos[0]) begin
        hold_nxt = in_packet_byte;
      end else begin
        csum_nxt = csum_add[15:0] + {15'd0, csum_add[16]};
      end
    end

    byte_count_nxt = (byte_count_r == COUNT_MAX) ? byte_count_r : byte_count_r + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      vihl_r       <= '0;
      tlen_r       <= '0;
      frag_r       <= '0;
      proto_r      <= '0;
      src_r        <= '0;
      dst_r        <= '0;
      csum_r       <= '0;
      hold_r       <= '0;
    end else if (in_acc) begin
      if (in_last_byte) begin
        byte_count_r <= '0;
        vihl_r       <= '0;
        tlen_r       <= '0;
        frag_r       <= '0;
        proto_r      <= '0;
        src_r        <= '0;
        dst_r        <= '0;
        csum_r       <= '0;
        hold_r       <= '0;
      end else begin
        byte_count_r <= byte_count_nxt;
        vihl_r       <= vihl_nxt;
        tlen_r       <= tlen_nxt;
        frag_r       <= frag_nxt;
        proto_r      <= proto_nxt;
        src_r        <= src_nxt;
        dst_r        <= dst_nxt;
        csum_r       <= csum_nxt;
        hold_r       <= hold_nxt;
      end
    end
  end

  // finished packet held for evaluation
  logic [15:0] snap_count_r;
  logic [7:0]  snap_vihl_r;
  logic [15:0] snap_tlen_r;
  logic [13:0] snap_frag_r;
  logic [7:0]  snap_proto_r;
  logic [31:0] snap_src_r;
  logic [31:0] snap_dst_r;
  logic [15:0] snap_csum_r;
  logic        snap_load;

  assign snap_load = in_acc && in_last_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_valid_r <= 1'b0;
    end else if (snap_load) begin
      snap_valid_r <= 1'b1;
    end else if (snap_move) begin
      snap_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_load) begin
      snap_count_r <= byte_count_nxt;
      snap_vihl_r  <= vihl_nxt;
      snap_tlen_r  <= tlen_nxt;
      snap_frag_r  <= frag_nxt[13:0];
      snap_proto_r <= proto_nxt;
      snap_src_r   <= src_nxt;
      snap_dst_r   <= dst_nxt;
      snap_csum_r  <= csum_nxt;
    end
  end

  // verdict
  logic [5:0]  hlen;
  logic [15:0] hlen_w;
  logic        dst_ours;
  verdict_t    verdict;
  logic [7:0]  res_proto;
  logic [31:0] res_src;
  logic [31:0] res_dst;
  logic [5:0]  res_hlen;
  logic [15:0] res_payload;

  assign hlen   = {snap_vihl_r[3:0], 2'b00};
  assign hlen_w = {10'd0, hlen};

  assign dst_ours = (snap_dst_r[31:24] == LOOPBACK_NET) ||
                    (snap_dst_r == local_addr_r) ||
                    (snap_dst_r == ALL_ONES_ADDR) ||
                    ((subnet_mask_r != '0) && (snap_dst_r == (local_addr_r | ~subnet_mask_r)));

  always_comb begin
    res_proto   = snap_proto_r;
    res_src     = snap_src_r;
    res_dst     = snap_dst_r;
    res_hlen    = hlen;
    res_payload = '0;
    if (snap_count_r < MIN_HEADER) begin
      verdict   = VERDICT_SHORT;
      res_proto = '0;
      res_src   = '0;
      res_dst   = '0;
      res_hlen  = '0;
    end else if (snap_vihl_r[7:4] != IP_VERSION4) begin
      verdict = VERDICT_VERSION;
    end else if (hlen_w < MIN_HEADER || hlen_w > snap_count_r) begin
      verdict = VERDICT_HDR_LEN;
    end else if (snap_csum_r != CSUM_GOOD) begin
      verdict = VERDICT_CHECKSUM;
    end else if (snap_tlen_r < hlen_w || snap_tlen_r > snap_count_r) begin
      verdict = VERDICT_TOT_LEN;
    end else if (!dst_ours) begin
      verdict = VERDICT_NOT_OURS;
    end else if (snap_frag_r != '0) begin
      verdict = VERDICT_FRAGMENT;
    end else if (snap_proto_r != PROTO_ICMP) begin
      verdict = VERDICT_PROTOCOL;
    end else begin
      verdict     = VERDICT_ACCEPT;
      res_payload = snap_tlen_r - hlen_w;
    end
  end

  // result word
  logic [3:0]  out_verdict_r;
  logic [7:0]  out_proto_r;
  logic [31:0] out_src_r;
  logic [31:0] out_dst_r;
  logic [5:0]  out_hlen_r;
  logic [15:0] out_payload_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= snap_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_move) begin
      out_verdict_r <= verdict;
      out_proto_r   <= res_proto;
      out_src_r     <= res_src;
      out_dst_r     <= res_dst;
      out_hlen_r    <= res_hlen;
      out_payload_r <= res_payload;
    end
  end

  assign out_verdict             = out_verdict_r;
  assign out_protocol_number     = out_proto_r;
  assign out_source_address      = out_src_r;
  assign out_destination_address = out_dst_r;
  assign out_header_bytes        = out_hlen_r;
  assign out_payload_bytes       = out_payload_r;

  // checks
  a_last_fills_snap: assert property (@(posedge clk) disable iff (!rst_n)
    snap_load |=> snap_valid_r)
    else $error("finished packet not held for evaluation");

  a_last_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    snap_load |=> byte_count_r == '0)
    else $error("byte count not cleared after last byte");

  a_count_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_last_byte) |=> byte_count_r != '0)
    else $error("byte count did not advance");

  a_payload_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_verdict_r != VERDICT_ACCEPT) |-> out_payload_r == '0)
    else $error("payload length given for a rejected packet");

  a_short_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_verdict_r == VERDICT_SHORT) |->
      (out_src_r == '0 && out_dst_r == '0 && out_proto_r == '0 && out_hlen_r == '0))
    else $error("short packet result carries header fields");

endmodule

// ===== test/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import irhc_pkg::*;

  localparam logic [15:0] FRAG_BITS = 16'h3FFF;
  localparam logic [15:0] FLAG_DF   = 16'h4000;
  localparam logic [15:0] FLAG_MF   = 16'h2000;
  localparam int          HOLD_CYCLES = 400;
  localparam int          DRAIN_LIMIT = 20000;

  typedef struct packed {
    verdict_t    verdict;
    logic [7:0]  proto;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [5:0]  header_len;
    logic [15:0] payload_len;
  } ip_result_t;

  typedef struct {
    logic [3:0]  version;
    logic [3:0]  ihl;
    logic [15:0] tot_len;
    logic [15:0] frag;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
    bit          sum_ok;
    int          body_len;
    int          cut;
  } ip_packet_t;

  typedef enum int {
    FLAW_VERSION, FLAW_IHL, FLAW_CHECKSUM, FLAW_TOTAL_LEN, FLAW_DEST,
    FLAW_FRAGMENT, FLAW_PROTOCOL, FLAW_SHORT, FLAW_TRUNCATE, FLAW_NOISE
  } flaw_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_packet_byte = 8'd0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_verdict;
  logic [7:0]  out_protocol_number;
  logic [31:0] out_source_address;
  logic [31:0] out_destination_address;
  logic [5:0]  out_header_bytes;
  logic [15:0] out_payload_bytes;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  ipv4_receive_header_check_core uut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_packet_byte          (in_packet_byte),
    .in_last_byte            (in_last_byte),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_verdict             (out_verdict),
    .out_protocol_number     (out_protocol_number),
    .out_source_address      (out_source_address),
    .out_destination_address (out_destination_address),
    .out_header_bytes        (out_header_bytes),
    .out_payload_bytes       (out_payload_bytes),
    .psel                    (psel),
    .penable                 (penable),
    .pwrite                  (pwrite),
    .paddr                   (paddr),
    .pwdata                  (pwdata),
    .prdata                  (prdata),
    .pready                  (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receive-side copy of the block's state and configuration
  logic [31:0] local_addr = 32'd0;
  logic [31:0] net_mask = 32'd0;
  logic [15:0] rx_count = 16'd0;
  logic [7:0]  rx_vihl = 8'd0;
  logic [15:0] rx_tlen = 16'd0;
  logic [15:0] rx_frag = 16'd0;
  logic [7:0]  rx_proto = 8'd0;
  logic [31:0] rx_src = 32'd0;
  logic [31:0] rx_dst = 32'd0;
  logic [15:0] rx_sum = 16'd0;
  logic [7:0]  rx_hold = 8'd0;

  ip_result_t pending_verdicts[$];

  int error_count = 0;
  int results_checked = 0;
  int bytes_sent = 0;
  int packets_sent = 0;
  int longest_packet = 0;
  int verdict_seen[9];
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  logic hold_go = 1'b0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= 40)
      $display("tb: %s mismatch at %0t ns: got %h, expected %h", what, $time, got, want);
  endtask

  function automatic bit dest_accepted(input logic [31:0] d);
    return d[31:24] == LOOPBACK_NET || d == local_addr || d == ALL_ONES_ADDR ||
           (net_mask != 32'd0 && d == (local_addr | ~net_mask));
  endfunction

  function automatic void predict_ip_byte(input logic [7:0] value, input logic last_flag);
    logic [15:0] pos;
    logic [15:0] hlen;
    logic [16:0] acc;
    verdict_t    v;
    ip_result_t  r;
    pos = rx_count;
    case (pos)
      POS_VIHL:    rx_vihl = value;
      POS_TLEN_HI: rx_tlen[15:8] = value;
      POS_TLEN_LO: rx_tlen[7:0] = value;
      POS_FRAG_HI: rx_frag[15:8] = value;
      POS_FRAG_LO: rx_frag[7:0] = value;
      POS_PROTO:   rx_proto = value;
      default: ;
    endcase
    if (pos >= POS_SRC_FIRST && pos <= POS_SRC_LAST) rx_src = {rx_src[23:0], value};
    else if (pos >= POS_DST_FIRST && pos <= POS_DST_LAST) rx_dst = {rx_dst[23:0], value};
    hlen = {10'd0, rx_vihl[3:0], 2'b00};
    if (pos < hlen) begin
      if (!pos[0]) begin
        rx_hold = value;
      end else begin
        acc = {1'b0, rx_sum} + {1'b0, rx_hold, value};
        rx_sum = acc[15:0] + 16'(acc[16]);
      end
    end
    if (rx_count != COUNT_MAX) rx_count++;
    if (!last_flag) return;

    r = '0;
    if (rx_count < MIN_HEADER) begin
      r.verdict = VERDICT_SHORT;
    end else begin
      if (rx_vihl[7:4] != IP_VERSION4) v = VERDICT_VERSION;
      else if (hlen < MIN_HEADER || hlen > rx_count) v = VERDICT_HDR_LEN;
      else if (rx_sum != CSUM_GOOD) v = VERDICT_CHECKSUM;
      else if (rx_tlen < hlen || rx_tlen > rx_count) v = VERDICT_TOT_LEN;
      else if (!dest_accepted(rx_dst)) v = VERDICT_NOT_OURS;
      else if ((rx_frag & FRAG_BITS) != 16'd0) v = VERDICT_FRAGMENT;
      else if (rx_proto != PROTO_ICMP) v = VERDICT_PROTOCOL;
      else v = VERDICT_ACCEPT;
      r.verdict = v;
      r.proto = rx_proto;
      r.src_ip = rx_src;
      r.dst_ip = rx_dst;
      r.header_len = hlen[5:0];
      r.payload_len = (v == VERDICT_ACCEPT) ? rx_tlen - hlen : 16'd0;
    end
    pending_verdicts.push_back(r);
    rx_count = 16'd0; rx_vihl = 8'd0; rx_tlen = 16'd0; rx_frag = 16'd0; rx_proto = 8'd0;
    rx_src = 32'd0; rx_dst = 32'd0; rx_sum = 16'd0; rx_hold = 8'd0;
  endfunction

  always @(posedge clk) begin : result_check
    ip_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("unexpected result, verdict", 32'(out_verdict), 32'd0);
      end else begin
        want = pending_verdicts.pop_front();
        results_checked++;
        verdict_seen[int'(want.verdict)]++;
        if (out_verdict !== want.verdict)
          report_mismatch("verdict", 32'(out_verdict), 32'(want.verdict));
        if (out_protocol_number !== want.proto)
          report_mismatch("protocol", 32'(out_protocol_number), 32'(want.proto));
        if (out_source_address !== want.src_ip)
          report_mismatch("source address", out_source_address, want.src_ip);
        if (out_destination_address !== want.dst_ip)
          report_mismatch("destination address", out_destination_address, want.dst_ip);
        if (out_header_bytes !== want.header_len)
          report_mismatch("header bytes", 32'(out_header_bytes), 32'(want.header_len));
        if (out_payload_bytes !== want.payload_len)
          report_mismatch("payload bytes", 32'(out_payload_bytes), 32'(want.payload_len));
      end
    end
  end

  // result-side stall, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_go) hold_left <= HOLD_CYCLES;
    else if (hold_left > 0) hold_left <= hold_left - 1;
    out_stall <= hold_go || hold_left > 0 || $urandom_range(0, 99) < stall_pct;
  end

  task automatic send_byte(input logic [7:0] value, input logic last_flag);
    in_valid <= 1'b1;
    in_packet_byte <= value;
    in_last_byte <= last_flag;
    do @(posedge clk); while (in_stall !== 1'b0);
    bytes_sent++;
    predict_ip_byte(value, last_flag);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
  endtask

  task automatic send_packet(input ip_packet_t p);
    logic [7:0]  wire_q[$];
    logic [15:0] sum;
    logic [16:0] acc;
    int          hdr_len;
    int          sum_len;
    int          i;
    hdr_len = int'(p.ihl) * 4;
    sum_len = hdr_len;
    if (hdr_len < 20) hdr_len = 20;
    wire_q.push_back({p.version, p.ihl});
    wire_q.push_back(8'($urandom));
    wire_q.push_back(p.tot_len[15:8]);
    wire_q.push_back(p.tot_len[7:0]);
    wire_q.push_back(8'($urandom));
    wire_q.push_back(8'($urandom));
    wire_q.push_back(p.frag[15:8]);
    wire_q.push_back(p.frag[7:0]);
    wire_q.push_back(8'($urandom));
    wire_q.push_back(p.proto);
    wire_q.push_back(8'($urandom));
    wire_q.push_back(8'($urandom));
    for (i = 24; i >= 0; i -= 8) wire_q.push_back(p.src[i +: 8]);
    for (i = 24; i >= 0; i -= 8) wire_q.push_back(p.dst[i +: 8]);
    while (wire_q.size() < hdr_len) wire_q.push_back(8'($urandom));
    if (p.sum_ok && sum_len >= 12) begin
      wire_q[10] = 8'd0;
      wire_q[11] = 8'd0;
      sum = 16'd0;
      for (i = 0; i < sum_len; i += 2) begin
        acc = {1'b0, sum} + {1'b0, wire_q[i], wire_q[i + 1]};
        sum = acc[15:0] + 16'(acc[16]);
      end
      wire_q[10] = ~sum[15:8];
      wire_q[11] = ~sum[7:0];
    end
    repeat (p.body_len) wire_q.push_back(8'($urandom));
    if (p.cut > 0) while (wire_q.size() > p.cut) void'(wire_q.pop_back());
    for (i = 0; i < wire_q.size(); i++) send_byte(wire_q[i], i == wire_q.size() - 1);
    packets_sent++;
    if (wire_q.size() > longest_packet) longest_packet = wire_q.size();
  endtask

  function automatic ip_packet_t make_packet(input logic [3:0] ihl, input int body,
                                             input logic [31:0] dst);
    ip_packet_t p;
    p.version = IP_VERSION4;
    p.ihl = ihl;
    p.tot_len = 16'(int'(ihl) * 4 + body);
    p.frag = 16'd0;
    p.proto = PROTO_ICMP;
    p.src = $urandom;
    p.dst = dst;
    p.sum_ok = 1'b1;
    p.body_len = body;
    p.cut = 0;
    return p;
  endfunction

  function automatic logic [31:0] pick_destination();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return local_addr;
    if (r < 6) return {LOOPBACK_NET, 24'($urandom)};
    if (r < 7) return ALL_ONES_ADDR;
    if (r < 9) return local_addr | ~net_mask;
    return $urandom;
  endfunction

  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (idx == REG_LOCAL_ADDR) local_addr = value;
    else net_mask = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== value) report_mismatch("register readback", prdata, value);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results(input int settle);
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_verdicts.size() != 0) begin
      report_mismatch("results still outstanding", pending_verdicts.size(), 32'd0);
      pending_verdicts.delete();
    end
    repeat (settle) @(posedge clk);
  endtask

  task automatic test_register_access();
    write_reg(REG_LOCAL_ADDR, 32'hFFFF_FFFF);
    write_reg(REG_SUBNET_MASK, 32'hFFFF_FFFF);
    write_reg(REG_LOCAL_ADDR, 32'h0000_0000);
    write_reg(REG_SUBNET_MASK, 32'h0000_0000);
    write_reg(REG_LOCAL_ADDR, 32'h5A5A_A5A5);
    write_reg(REG_SUBNET_MASK, 32'hA5A5_5A5A);
    write_reg(REG_LOCAL_ADDR, 32'hC0A8_0105);
    write_reg(REG_SUBNET_MASK, 32'hFFFF_FF00);
  endtask

  task automatic test_short_packets();
    ip_packet_t p;
    int n;
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    for (n = 2; n <= 20; n += 17) begin
      p = make_packet(4'd5, 0, local_addr);
      p.cut = n;
      send_packet(p);
    end
    p = make_packet(4'd5, 0, local_addr);
    p.cut = 19;
    send_packet(p);
    drain_results(4);
  endtask

  task automatic test_header_checks();
    ip_packet_t p;
    send_packet(make_packet(4'd5, 0, local_addr));
    send_packet(make_packet(4'd15, 8, local_addr));
    p = make_packet(4'd5, 3, local_addr);
    p.version = 4'd6;
    send_packet(p);
    p = make_packet(4'd5, 3, local_addr);
    p.ihl = 4'd4;
    send_packet(p);
    p = make_packet(4'd5, 3, local_addr);
    p.ihl = 4'd0;
    send_packet(p);
    // header longer than the packet itself
    p = make_packet(4'd15, 0, local_addr);
    p.cut = 40;
    send_packet(p);
    p = make_packet(4'd5, 3, local_addr);
    p.sum_ok = 1'b0;
    send_packet(p);
    p = make_packet(4'd5, 3, local_addr);
    p.tot_len = 16'd19;
    send_packet(p);
    p = make_packet(4'd5, 4, local_addr);
    p.tot_len = 16'd25;
    send_packet(p);
    // trailing padding is trimmed
    p = make_packet(4'd5, 6, local_addr);
    p.tot_len = 16'd22;
    send_packet(p);
    drain_results(4);
  endtask

  task automatic test_destination_match();
    logic [31:0] dst_list[9] = '{32'hC0A8_0105, 32'h7F00_0001, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                                 32'hC0A8_01FF, 32'h0A00_0001, 32'h7EFF_FFFF, 32'h8000_0000,
                                 32'hC0A8_0106};
    write_reg(REG_LOCAL_ADDR, 32'hC0A8_0105);
    write_reg(REG_SUBNET_MASK, 32'hFFFF_FF00);
    foreach (dst_list[i]) send_packet(make_packet(4'd5, 2, dst_list[i]));
    drain_results(4);
    write_reg(REG_LOCAL_ADDR, 32'h0000_0000);
    write_reg(REG_SUBNET_MASK, 32'hFFFF_FFFF);
    send_packet(make_packet(4'd5, 1, 32'h0000_0000));
    send_packet(make_packet(4'd5, 1, 32'h0000_0001));
    drain_results(4);
    write_reg(REG_SUBNET_MASK, 32'h0000_0000);
    send_packet(make_packet(4'd5, 1, 32'h0000_00FF));
    send_packet(make_packet(4'd5, 1, 32'h0000_0000));
    drain_results(4);
    write_reg(REG_LOCAL_ADDR, 32'hC0A8_0105);
    write_reg(REG_SUBNET_MASK, 32'hFFFF_FF00);
  endtask

  task automatic test_fragment_and_protocol();
    ip_packet_t p;
    logic [15:0] frag_list[4] = '{FLAG_MF, 16'h0001, 16'h1FFF, FLAG_DF};
    logic [7:0]  proto_list[4] = '{8'd6, 8'd17, 8'd0, 8'd255};
    foreach (frag_list[i]) begin
      p = make_packet(4'd5, 2, local_addr);
      p.frag = frag_list[i];
      send_packet(p);
    end
    foreach (proto_list[i]) begin
      p = make_packet(4'd5, 2, local_addr);
      p.proto = proto_list[i];
      send_packet(p);
    end
    drain_results(4);
  endtask

  task automatic test_backpressure();
    ip_packet_t p;
    int n;
    idle_pct = 0;
    stall_pct = 0;
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    for (n = 0; n < 12; n++) begin
      p = make_packet(4'd5, n % 4, local_addr);
      if (n % 3 == 0) p.cut = n + 1;
      send_packet(p);
    end
    drain_results(4);
  endtask

  task automatic send_random_packet();
    ip_packet_t p;
    logic [3:0] ihl;
    int body;
    int pad;
    int hdr;
    flaw_t flaw;
    ihl = ($urandom_range(0, 99) < 75) ? 4'd5 : 4'($urandom_range(6, 15));
    body = $urandom_range(0, 24);
    pad = $urandom_range(0, body < 3 ? body : 3);
    p = make_packet(ihl, body, pick_destination());
    p.tot_len = p.tot_len - 16'(pad);
    if ($urandom_range(0, 99) < 20) p.frag = FLAG_DF;
    if ($urandom_range(0, 99) >= 65) begin
      flaw = flaw_t'($urandom_range(0, int'(FLAW_NOISE)));
      hdr = int'(ihl) * 4;
      case (flaw)
        FLAW_VERSION:   p.version = 4'($urandom);
        FLAW_IHL:       p.ihl = 4'($urandom);
        FLAW_CHECKSUM:  p.sum_ok = 1'b0;
        FLAW_TOTAL_LEN: p.tot_len = 16'($urandom);
        FLAW_DEST:      p.dst = $urandom;
        FLAW_FRAGMENT:  p.frag = 16'($urandom);
        FLAW_PROTOCOL:  p.proto = 8'($urandom);
        FLAW_SHORT:     p.cut = $urandom_range(1, 19);
        FLAW_TRUNCATE:  p.cut = $urandom_range(20, hdr + body);
        default: begin
          p.version = 4'($urandom);
          p.ihl = 4'($urandom);
          p.tot_len = 16'($urandom);
          p.frag = 16'($urandom);
          p.proto = 8'($urandom);
          p.dst = $urandom;
          p.sum_ok = $urandom_range(0, 1);
          p.body_len = $urandom_range(0, 30);
          p.cut = $urandom_range(0, 1) ? $urandom_range(1, 40) : 0;
        end
      endcase
    end
    send_packet(p);
  endtask

  task automatic test_random_traffic();
    int phase;
    int start;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
          write_reg(REG_LOCAL_ADDR, $urandom);
          write_reg(REG_SUBNET_MASK, 32'hFFFF_FF00);
        end
        1: begin
          idle_pct = 64;
          stall_pct = 0;
          write_reg(REG_LOCAL_ADDR, 32'hFFFF_FFFF);
          write_reg(REG_SUBNET_MASK, 32'hFFFF_FFFF);
        end
        2: begin
          idle_pct = 0;
          stall_pct = 64;
          write_reg(REG_LOCAL_ADDR, 32'h0000_0000);
          write_reg(REG_SUBNET_MASK, 32'h0000_0000);
        end
        default: begin
          idle_pct = 28;
          stall_pct = 28;
          write_reg(REG_LOCAL_ADDR, $urandom);
          write_reg(REG_SUBNET_MASK, $urandom);
        end
      endcase
      start = bytes_sent;
      while (bytes_sent - start < 120) send_random_packet();
      drain_results(4);
    end
  endtask

  initial begin : run_tests
    string mix;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_access();
    idle_pct = 28;
    stall_pct = 28;
    test_short_packets();
    test_header_checks();
    test_destination_match();
    test_fragment_and_protocol();
    test_backpressure();
    test_random_traffic();
    drain_results(8);
    mix = "";
    foreach (verdict_seen[v]) mix = {mix, $sformatf(" %0d", verdict_seen[v])};
    $display("tb: %0d packets in %0d words (longest %0d), %0d verdicts compared",
             packets_sent, bytes_sent, longest_packet, results_checked);
    $display("tb: verdict counts, accept through protocol:%s", mix);
    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("tb: timed out");
    $display("tb: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/irhc_pkg.sv
rtl/ipv4_receive_header_check_core.sv
test/tb.sv
